// ----- src/bs3_pkg.sv -----
`default_nettype none

package bs3_pkg;

	// fixed field widths and the reset image size
	localparam int CFG_W          = 11;
	localparam int POS_W          = 10;
	localparam int CFG_RESET_SIZE = 1024;

	// kind of input transaction
	typedef enum logic {
		OP_PIXEL = 1'b0,
		OP_DRAIN = 1'b1
	} op_t;

	// divisor of the clipped window: corner, edge, interior
	typedef enum logic [1:0] {
		DIV_4,
		DIV_6,
		DIV_9
	} div_sel_t;

	// control that travels with an item down the pipeline
	typedef struct packed {
		logic             valid;
		logic             pixel;
		logic             emit;
		logic             last;
		logic             top_en;
		logic             bot_en;
		logic             left_en;
		logic             right_en;
		div_sel_t         div_sel;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
	} stage_ctrl_t;

endpackage

`default_nettype wire

// ----- src/bs3_ram.sv -----
`default_nettype none

module bs3_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ----- src/box_smooth_3x3_rgb.sv -----
`default_nettype none

// 3x3 box filter over a square RGB image streamed in raster order. Each output pixel is the
// truncated mean of each channel over its 3x3 neighborhood clipped to the image (4 values at
// corners, 6 on edges, 9 inside). The block takes one transaction per clock; the result for
// raster position k leaves with the input at position k + size + 1, and after the last pixel
// size + 1 drain transactions (tuser = 1) flush the rest; tlast marks the final output of the
// frame. Drain transactions during a frame and pixels after the frame end are dropped. A
// result passes pipeline registers s1, s2 and s3 into the output queue; the 8-entry output
// queue sets s_tready, so input stalls only when the queue and the pipeline hold 8 pending
// results. The two previous rows live in one MAX_DIM-deep RAM (one read and one write port),
// which needs no clearing after reset. image_size must be written only while the block is
// idle, not enforced by the block; values below 2 act as 2 and above MAX_DIM as MAX_DIM.
module box_smooth_3x3_rgb #(
	parameter int MAX_DIM      = 1024,
	parameter int CHANNEL_BITS = 16,
	localparam int IN_W  = ((3 * CHANNEL_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((3 * CHANNEL_BITS + 2 * bs3_pkg::POS_W + 7) / 8) * 8
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// configuration: image_size
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [bs3_pkg::CFG_W-1:0]   cfg_data,
	// input stream
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	input  wire logic [IN_W-1:0]             s_tdata,  // pixel_red, pixel_green, pixel_blue
	input  wire logic                        s_tuser,  // operation
	// output stream
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic      [OUT_W-1:0]            m_tdata,  // out_red, out_green, out_blue, out_row, out_col
	output logic                             m_tlast   // frame_last
);

	localparam int CB       = CHANNEL_BITS;
	localparam int PX_W     = 3 * CB;
	localparam int CW       = $clog2(MAX_DIM);
	localparam int DW       = CW + 1;
	localparam int SW       = CB + 4;
	localparam int PROD_W   = 2 * SW + 1;
	localparam int SH6      = SW + 1;
	localparam int SH9      = SW + 4;
	localparam int CMP_W    = (DW > bs3_pkg::CFG_W) ? DW : bs3_pkg::CFG_W;
	localparam int RST_DIM  = (MAX_DIM < bs3_pkg::CFG_RESET_SIZE) ? MAX_DIM
	                          : bs3_pkg::CFG_RESET_SIZE;
	localparam int ENT_W    = PX_W + 2 * bs3_pkg::POS_W + 1;
	localparam int Q_DEPTH  = 8;
	localparam int QP_W     = 3;
	localparam int OCC_W    = QP_W + 1;

	// reciprocals for exact division: sum/6 = (sum/2)/3, sum/9
	localparam logic [SW:0] RCP3 = (SW + 1)'((2 ** (SW + 1) + 2) / 3);
	localparam logic [SW:0] RCP9 = (SW + 1)'((2 ** (SW + 4) + 8) / 9);

	// state registers
	logic [DW-1:0]       dim_q;
	logic [CW-1:0]       in_col_q;
	logic [CW-1:0]       in_row_q;
	logic [CW-1:0]       emit_col_q;
	logic [CW-1:0]       emit_row_q;
	logic                done_q;

	// pipeline registers
	bs3_pkg::stage_ctrl_t ctrl_s1, ctrl_s2, ctrl_s3;
	logic [PX_W-1:0]     px_s1;
	logic [CW-1:0]       x_s1;
	logic [PX_W-1:0]     window_q [3][3];
	logic [SW-1:0]       sum_s3 [3];

	// output queue
	logic [ENT_W-1:0]    queue_q [Q_DEPTH];
	logic [OCC_W-1:0]    wr_ptr_q, rd_ptr_q, occ_q;

	// combinational signals
	logic                accept, pop, push_q, is_pix, pix_ok, drn_ok;
	logic                col_end, row_end, e_col_end, e_row_end, e_last, emit0;
	logic                rows_part, cols_part;
	bs3_pkg::stage_ctrl_t ctrl0;
	logic [DW-1:0]       x_w, row_w, ecol_w, erow_w;
	logic [CMP_W-1:0]    cfg_wide;
	logic [DW-1:0]       dim_next;
	logic [2*PX_W-1:0]   ram_rdata;
	logic [PX_W-1:0]     top_px, mid_px;
	logic [2:0]          row_on, col_on;
	logic [SW-1:0]       col_sum [3][3];
	logic [SW-1:0]       sum_next [3];
	logic [SW-1:0]       mul_a [3];
	logic [SW:0]         mul_b [3];
	logic [PROD_W-1:0]   prod [3];
	logic [CB-1:0]       quot [3];
	logic [ENT_W-1:0]    entry;

	assign cfg_ready = 1'b1;
	assign accept    = s_tvalid && s_tready;
	assign s_tready  = (occ_q < OCC_W'(Q_DEPTH));
	assign m_tvalid  = (wr_ptr_q != rd_ptr_q);
	assign pop       = m_tvalid && m_tready;

	// clamp the configured size
	always_comb begin
		cfg_wide = CMP_W'(cfg_data);
		if (cfg_wide < CMP_W'(2)) begin
			dim_next = DW'(2);
		end else if (cfg_wide > CMP_W'(MAX_DIM)) begin
			dim_next = DW'(MAX_DIM);
		end else begin
			dim_next = DW'(cfg_wide);
		end
	end

	// input side decode and position bookkeeping
	always_comb begin
		is_pix    = (bs3_pkg::op_t'(s_tuser) == bs3_pkg::OP_PIXEL);
		pix_ok    = is_pix && !done_q;
		drn_ok    = !is_pix && done_q;
		x_w       = DW'(in_col_q);
		row_w     = DW'(in_row_q);
		ecol_w    = DW'(emit_col_q);
		erow_w    = DW'(emit_row_q);
		col_end   = (x_w + DW'(1)) >= dim_q;
		row_end   = (row_w + DW'(1)) >= dim_q;
		e_col_end = (ecol_w + DW'(1)) >= dim_q;
		e_row_end = (erow_w + DW'(1)) >= dim_q;
		e_last    = e_col_end && e_row_end;
		emit0     = (pix_ok && ((row_w >= DW'(2)) || ((row_w == DW'(1)) && (x_w != '0))))
		            || drn_ok;

		ctrl0.valid    = accept && (pix_ok || drn_ok);
		ctrl0.pixel    = pix_ok;
		ctrl0.emit     = accept && emit0;
		ctrl0.last     = e_last;
		ctrl0.top_en   = (emit_row_q != '0);
		ctrl0.bot_en   = !e_row_end;
		ctrl0.left_en  = (emit_col_q != '0);
		ctrl0.right_en = !e_col_end;
		rows_part      = !(ctrl0.top_en && ctrl0.bot_en);
		cols_part      = !(ctrl0.left_en && ctrl0.right_en);
		if (rows_part && cols_part) begin
			ctrl0.div_sel = bs3_pkg::DIV_4;
		end else if (rows_part || cols_part) begin
			ctrl0.div_sel = bs3_pkg::DIV_6;
		end else begin
			ctrl0.div_sel = bs3_pkg::DIV_9;
		end
		ctrl0.row = bs3_pkg::POS_W'(emit_row_q);
		ctrl0.col = bs3_pkg::POS_W'(emit_col_q);
	end

	// control state, pipeline valid and queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q      <= DW'(RST_DIM);
			in_col_q   <= '0;
			in_row_q   <= '0;
			emit_col_q <= '0;
			emit_row_q <= '0;
			done_q     <= 1'b0;
			ctrl_s1    <= '0;
			ctrl_s2    <= '0;
			ctrl_s3    <= '0;
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			occ_q      <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				dim_q <= dim_next;
			end

			// input position
			if (accept && pix_ok) begin
				if (col_end) begin
					in_col_q <= '0;
					if (row_end) begin
						in_row_q <= '0;
						done_q   <= 1'b1;
					end else begin
						in_row_q <= in_row_q + CW'(1);
					end
				end else begin
					in_col_q <= in_col_q + CW'(1);
				end
			end else if (accept && drn_ok) begin
				if (e_last) begin
					done_q   <= 1'b0;
					in_row_q <= '0;
					in_col_q <= '0;
				end else if (col_end) begin
					in_col_q <= '0;
				end else begin
					in_col_q <= in_col_q + CW'(1);
				end
			end

			// output position
			if (ctrl0.emit) begin
				if (e_last) begin
					emit_col_q <= '0;
					emit_row_q <= '0;
				end else if (e_col_end) begin
					emit_col_q <= '0;
					emit_row_q <= emit_row_q + CW'(1);
				end else begin
					emit_col_q <= emit_col_q + CW'(1);
				end
			end

			ctrl_s1 <= ctrl0;
			ctrl_s2 <= ctrl_s1;
			ctrl_s3 <= ctrl_s2;

			// queue pointers and pending result count
			if (push_q) begin
				wr_ptr_q <= wr_ptr_q + OCC_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + OCC_W'(1);
			end
			occ_q <= occ_q + OCC_W'(ctrl0.emit) - OCC_W'(pop);
		end
	end

	// line store: older row in the upper half, newer row in the lower half
	bs3_ram #(
		.WIDTH (2 * PX_W),
		.DEPTH (MAX_DIM)
	) u_line_ram (
		.clk   (clk),
		.we    (ctrl_s1.valid && ctrl_s1.pixel),
		.waddr (x_s1),
		.wdata ({mid_px, px_s1}),
		.raddr (in_col_q),
		.rdata (ram_rdata)
	);

	assign top_px = ram_rdata[2*PX_W-1:PX_W];
	assign mid_px = ram_rdata[PX_W-1:0];

	// clipped window sums per channel
	always_comb begin
		row_on = {ctrl_s2.bot_en, 1'b1, ctrl_s2.top_en};
		col_on = {ctrl_s2.right_en, 1'b1, ctrl_s2.left_en};
		for (int k = 0; k < 3; k++) begin
			for (int c = 0; c < 3; c++) begin
				col_sum[k][c] =
					((row_on[0] && col_on[c]) ? SW'(window_q[0][c][k*CB +: CB]) : '0) +
					((row_on[1] && col_on[c]) ? SW'(window_q[1][c][k*CB +: CB]) : '0) +
					((row_on[2] && col_on[c]) ? SW'(window_q[2][c][k*CB +: CB]) : '0);
			end
			sum_next[k] = col_sum[k][0] + col_sum[k][1] + col_sum[k][2];
		end
	end

	// division by 4 through a shift, by 6 or 9 through one reciprocal multiply per channel
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			if (ctrl_s3.div_sel == bs3_pkg::DIV_6) begin
				mul_a[k] = sum_s3[k] >> 1;
				mul_b[k] = RCP3;
			end else begin
				mul_a[k] = sum_s3[k];
				mul_b[k] = RCP9;
			end
			prod[k] = PROD_W'(mul_a[k]) * PROD_W'(mul_b[k]);
			unique case (ctrl_s3.div_sel)
				bs3_pkg::DIV_4: begin
					quot[k] = CB'(sum_s3[k] >> 2);
				end
				bs3_pkg::DIV_6: begin
					quot[k] = CB'(prod[k] >> SH6);
				end
				bs3_pkg::DIV_9: begin
					quot[k] = CB'(prod[k] >> SH9);
				end
				default: begin
					quot[k] = '0;
				end
			endcase
		end
		entry  = {ctrl_s3.last, ctrl_s3.col, ctrl_s3.row, quot[2], quot[1], quot[0]};
		push_q = ctrl_s3.valid && ctrl_s3.emit;
	end

	// payload registers: input stage, window, sums, queue
	always_ff @(posedge clk) begin
		px_s1 <= s_tdata[PX_W-1:0];
		x_s1  <= in_col_q;
		if (ctrl_s1.valid) begin
			for (int r = 0; r < 3; r++) begin
				window_q[r][0] <= window_q[r][1];
				window_q[r][1] <= window_q[r][2];
			end
			window_q[0][2] <= top_px;
			window_q[1][2] <= mid_px;
			window_q[2][2] <= ctrl_s1.pixel ? px_s1 : '0;
		end
		for (int k = 0; k < 3; k++) begin
			sum_s3[k] <= sum_next[k];
		end
		if (push_q) begin
			queue_q[wr_ptr_q[QP_W-1:0]] <= entry;
		end
	end

	// output transaction from the queue head
	assign m_tdata = OUT_W'(queue_q[rd_ptr_q[QP_W-1:0]][ENT_W-2:0]);
	assign m_tlast = queue_q[rd_ptr_q[QP_W-1:0]][ENT_W-1];

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LINE_MAX    = 1024;
	localparam int QUIET_LIMIT = 4000;

	// one smoothed output pixel as it leaves the block
	typedef struct {
		logic [15:0]               red;
		logic [15:0]               green;
		logic [15:0]               blue;
		logic [bs3_pkg::POS_W-1:0] row;
		logic [bs3_pkg::POS_W-1:0] col;
		logic                      last;
	} smooth_px_t;

	// tracks the filter state and the smoothed pixels still owed by the block
	class mean_tracker;
		logic [bs3_pkg::CFG_W-1:0] size_reg;
		logic [47:0]      older_row [LINE_MAX];
		logic [47:0]      newer_row [LINE_MAX];
		logic [47:0]      win [3][3];
		int unsigned      in_row;
		int unsigned      in_col;
		int unsigned      out_row;
		int unsigned      out_col;
		bit               frame_done;
		smooth_px_t       expected_q [$];
		int               errors;

		function new();
			size_reg = bs3_pkg::CFG_W'(bs3_pkg::CFG_RESET_SIZE);
			foreach (older_row[i]) begin
				older_row[i] = '0;
				newer_row[i] = '0;
			end
			foreach (win[r, c]) win[r][c] = '0;
			in_row = 0;
			in_col = 0;
			out_row = 0;
			out_col = 0;
			frame_done = 1'b0;
			errors = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// sizes outside the supported range are clamped
		function int unsigned dim();
			if (size_reg < 2) return 2;
			if (size_reg > LINE_MAX) return LINE_MAX;
			return size_reg;
		endfunction

		function void shift_window(logic [47:0] top, logic [47:0] mid, logic [47:0] bot);
			for (int r = 0; r < 3; r++) begin
				win[r][0] = win[r][1];
				win[r][1] = win[r][2];
			end
			win[0][2] = top;
			win[1][2] = mid;
			win[2][2] = bot;
		endfunction

		// mean over the window center, clipped at the image border
		function bit emit_mean(int unsigned d);
			int unsigned r0, r1, c0, c1, cnt;
			int unsigned sum [3];
			smooth_px_t  e;
			bit          last;
			r0 = (out_row > 0) ? 0 : 1;
			r1 = (out_row + 1 < d) ? 2 : 1;
			c0 = (out_col > 0) ? 0 : 1;
			c1 = (out_col + 1 < d) ? 2 : 1;
			sum = '{0, 0, 0};
			cnt = 0;
			for (int unsigned r = r0; r <= r1; r++)
				for (int unsigned c = c0; c <= c1; c++) begin
					for (int k = 0; k < 3; k++) sum[k] += win[r][c][16*k +: 16];
					cnt++;
				end
			last = (out_row + 1 >= d) && (out_col + 1 >= d);
			e.red = 16'(sum[0] / cnt);
			e.green = 16'(sum[1] / cnt);
			e.blue = 16'(sum[2] / cnt);
			e.row = bs3_pkg::POS_W'(out_row);
			e.col = bs3_pkg::POS_W'(out_col);
			e.last = last;
			expected_q.push_back(e);
			// advance the output position
			if (last) begin
				out_row = 0;
				out_col = 0;
			end else if (out_col + 1 >= d) begin
				out_col = 0;
				out_row = out_row + 1;
			end else begin
				out_col = out_col + 1;
			end
			return last;
		endfunction

		function void accept_item(bs3_pkg::op_t op, logic [47:0] px);
			int unsigned d, x, row;
			logic [47:0] top, mid;
			bit          hit;
			d = dim();
			x = in_col;
			row = in_row;
			top = '0;
			mid = '0;
			if (op == bs3_pkg::OP_PIXEL) begin
				// pixels past the frame end are dropped
				if (frame_done) return;
				if (x < LINE_MAX) begin
					top = older_row[x];
					mid = newer_row[x];
					older_row[x] = mid;
					newer_row[x] = px;
				end
				shift_window(top, mid, px);
				hit = (row >= 2) || (row == 1 && x >= 1);
				if (x + 1 >= d) begin
					in_col = 0;
					if (row + 1 >= d) begin
						in_row = 0;
						frame_done = 1'b1;
					end else begin
						in_row = row + 1;
					end
				end else begin
					in_col = x + 1;
				end
				if (hit) void'(emit_mean(d));
			end else begin
				// drains inside a frame are dropped
				if (!frame_done) return;
				if (!((out_row + 1 >= d) && (out_col + 1 >= d))) begin
					if (x < LINE_MAX) begin
						top = older_row[x];
						mid = newer_row[x];
					end
					in_col = (x + 1 >= d) ? 0 : x + 1;
				end
				shift_window(top, mid, '0);
				if (emit_mean(d)) begin
					frame_done = 1'b0;
					in_row = 0;
					in_col = 0;
				end
			end
		endfunction

		function void compare_field(string name, logic [15:0] want, logic [15:0] seen);
			if (want !== seen) begin
				errors++;
				$error("%s: expected %0h, got %0h", name, want, seen);
			end
		endfunction

		function void check_mean(smooth_px_t got);
			smooth_px_t e;
			if (expected_q.size() == 0) begin
				errors++;
				$error("output pixel with nothing pending: row %0d col %0d", got.row, got.col);
				return;
			end
			e = expected_q.pop_front();
			compare_field("out_red", e.red, got.red);
			compare_field("out_green", e.green, got.green);
			compare_field("out_blue", e.blue, got.blue);
			compare_field("out_row", 16'(e.row), 16'(got.row));
			compare_field("out_col", 16'(e.col), 16'(got.col));
			compare_field("frame_last", 16'(e.last), 16'(got.last));
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [bs3_pkg::CFG_W-1:0] cfg_data;
	logic             s_tvalid;
	logic             s_tready;
	logic [47:0]      s_tdata;   // pixel_red, pixel_green, pixel_blue
	logic             s_tuser;   // operation
	logic             m_tvalid;
	logic             m_tready;
	logic [71:0]      m_tdata;   // out_red, out_green, out_blue, out_row, out_col
	logic             m_tlast;   // frame_last

	mean_tracker tracker = new();

	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_cycles = 0;
	int counted = 0;
	int quiet_cycles = 0;

	box_smooth_3x3_rgb u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	// clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: long hold-off when requested, else random stalls
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				m_tready = 1'b0;
				hold_cycles--;
			end else begin
				m_tready = ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// output monitor
	always @(posedge clk) begin
		smooth_px_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.red = m_tdata[15:0];
			got.green = m_tdata[31:16];
			got.blue = m_tdata[47:32];
			got.row = m_tdata[57:48];
			got.col = m_tdata[67:58];
			got.last = m_tlast;
			tracker.check_mean(got);
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
				if (quiet_cycles >= QUIET_LIMIT) begin
					$display("SCOREBOARD MISMATCH");
					$finish;
				end
			end
		end
	end

	function automatic logic [15:0] pick_channel();
		case ($urandom_range(7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [47:0] random_pixel();
		return {pick_channel(), pick_channel(), pick_channel()};
	endfunction

	// mostly small frames, a few larger ones, now and then a clamped size
	function automatic logic [bs3_pkg::CFG_W-1:0] choose_size();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 8) return bs3_pkg::CFG_W'($urandom_range(1));
		if (pick < 80) return bs3_pkg::CFG_W'($urandom_range(8, 2));
		return bs3_pkg::CFG_W'($urandom_range(14, 9));
	endfunction

	// one input transaction, called and returning at a falling edge
	task automatic send_item(bs3_pkg::op_t op, logic [47:0] px);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = op;
		s_tdata = px;
		do @(posedge clk); while (!s_tready);
		tracker.accept_item(op, px);
		@(negedge clk);
	endtask

	task automatic write_image_size(logic [bs3_pkg::CFG_W-1:0] value);
		cfg_valid = 1'b1;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		tracker.size_reg = value;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// hold the sender until every output has come, plus pipeline latency
	task automatic wait_idle();
		s_tvalid = 1'b0;
		while (tracker.pending() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_idling(int send_pct, int recv_pct);
		@(posedge clk);
		send_idle_pct = send_pct;
		stall_pct = recv_pct;
		@(negedge clk);
	endtask

	// pixels up to the frame end, then drains until the frame closes,
	// with stray drains and pixels mixed in that the block drops
	task automatic finish_frame(int noise_pct);
		while (!tracker.frame_done) begin
			if ($urandom_range(99) < noise_pct) send_item(bs3_pkg::OP_DRAIN, random_pixel());
			send_item(bs3_pkg::OP_PIXEL, random_pixel());
			counted++;
		end
		while (tracker.frame_done) begin
			if ($urandom_range(99) < noise_pct) send_item(bs3_pkg::OP_PIXEL, random_pixel());
			send_item(bs3_pkg::OP_DRAIN, random_pixel());
			counted++;
		end
		if ($urandom_range(99) < noise_pct) send_item(bs3_pkg::OP_DRAIN, random_pixel());
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// size 0 clamps to 2: full-scale pixels, drain inside the frame,
		// pixel past the frame end, drain after the frame closes
		write_image_size(bs3_pkg::CFG_W'(0));
		send_item(bs3_pkg::OP_PIXEL, {3{16'hFFFF}});
		send_item(bs3_pkg::OP_PIXEL, {3{16'hFFFF}});
		send_item(bs3_pkg::OP_DRAIN, 48'h0);
		send_item(bs3_pkg::OP_PIXEL, {16'h8000, 16'hFFFF, 16'h0001});
		send_item(bs3_pkg::OP_PIXEL, 48'h0);
		send_item(bs3_pkg::OP_PIXEL, {3{16'hFFFF}});
		repeat (3) send_item(bs3_pkg::OP_DRAIN, {3{16'hFFFF}});
		send_item(bs3_pkg::OP_DRAIN, 48'h0);
		wait_idle();

		// smallest frame with an interior pixel
		write_image_size(bs3_pkg::CFG_W'(3));
		finish_frame(0);
		wait_idle();

		// largest register value: part of the first row, then shrink mid-frame
		write_image_size({bs3_pkg::CFG_W{1'b1}});
		repeat (40) send_item(bs3_pkg::OP_PIXEL, random_pixel());
		wait_idle();
		write_image_size(bs3_pkg::CFG_W'(3));
		finish_frame(0);
		wait_idle();

		// random frames under each idling mix
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: set_idling(0, 0);
				1: set_idling(77, 0);
				2: set_idling(0, 77);
				default: set_idling(23, 23);
			endcase
			counted = 0;
			while (counted < 150) begin
				if (ph == 0 && counted == 0) begin
					// long receiver hold-off while a 12x12 frame streams in
					wait_idle();
					write_image_size(bs3_pkg::CFG_W'(12));
					@(posedge clk);
					hold_cycles = 200;
					@(negedge clk);
				end else if ($urandom_range(1) == 1) begin
					wait_idle();
					write_image_size(choose_size());
				end
				finish_frame(10);
			end
		end

		wait_idle();
		if (tracker.errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ----- filelist.f -----
src/bs3_pkg.sv
src/bs3_ram.sv
src/box_smooth_3x3_rgb.sv
tb/tb.sv
